/* rtl/assert_macros.svh */
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge, reset included.
`define ASSERT_CLK(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) else $error("assertion failed");

// Property checked only while reset is released (active-low reset).
`define ASSERT_RST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

`endif

/* rtl/utf8_dec_pkg.sv */
// Package with widths, result type and decode function of the UTF-8 decoder.
`timescale 1ns / 1ps
`default_nettype none

package utf8_dec_pkg;

    localparam int BYTE_W      = 8;
    localparam int CP_W        = 21;
    localparam int PART_W      = 15;
    localparam int OWED_W      = 2;
    localparam int OUT_TDATA_W = 24;

    typedef struct packed {
        logic              emit;
        logic [CP_W-1:0]   cp;
        logic [PART_W-1:0] next_partial;
        logic [OWED_W-1:0] next_owed;
    } t_dec_result;

    // One decode step: current pending state plus one byte gives the new
    // pending state and, when a codepoint completes, the codepoint.
    function automatic t_dec_result f_decode(
        input logic [OWED_W-1:0] owed,
        input logic [PART_W-1:0] part,
        input logic [BYTE_W-1:0] b
    );
        t_dec_result       res;
        logic [CP_W-1:0]   cp;
        logic [OWED_W-1:0] owed_m1;
        res     = '0;
        cp      = {part, b[5:0]};
        owed_m1 = owed - 2'd1;
        if (b == '0) begin
            // End of text: pending state is cleared, nothing is emitted.
        end else if ((owed != '0) && (b[7:6] == 2'b10)) begin
            res.next_owed = owed_m1;
            if (owed_m1 != '0) begin
                res.next_partial = cp[PART_W-1:0];
            end else begin
                res.emit = (cp != '0);
                res.cp   = cp;
            end
        end else begin
            // A fresh byte; any partial sequence is abandoned.
            case (b) inside
                [8'h01:8'h7F]: begin
                    res.emit = 1'b1;
                    res.cp   = {{(CP_W-BYTE_W){1'b0}}, b};
                end
                [8'hC0:8'hDF]: begin
                    res.next_partial = {{(PART_W-5){1'b0}}, b[4:0]};
                    res.next_owed    = 2'd1;
                end
                [8'hE0:8'hEF]: begin
                    res.next_partial = {{(PART_W-4){1'b0}}, b[3:0]};
                    res.next_owed    = 2'd2;
                end
                [8'hF0:8'hF7]: begin
                    res.next_partial = {{(PART_W-3){1'b0}}, b[2:0]};
                    res.next_owed    = 2'd3;
                end
                default: begin
                    // Stray continuation or invalid lead: dropped.
                end
            endcase
        end
        return res;
    endfunction

endpackage

`default_nettype wire

/* rtl/utf8_to_codepoint_decoder_top.sv */
// Top level of the UTF-8 byte stream to codepoint decoder.
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Direction | tdata fields (lowest bit up)       | Width
// s (input) | in        | text_byte [7:0]                    | 8
// m (output)| out       | codepoint [20:0], zero pad [23:21] | 24
//
// The decoder takes one byte per cycle when the output side keeps up.
// An accepted byte is registered in the input register and decoded out of it
// once the result register has room; a codepoint it completes is registered there.
// The synchronous active-low reset empties both registers and clears the
// pending sequence. A stalled result register holds its codepoint, and the
// input register takes one more byte before input ready drops.

module utf8_to_codepoint_decoder_top
    import utf8_dec_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_tvalid,
    output logic                        o_s_tready,
    input  wire logic [BYTE_W-1:0]      i_s_tdata,   // text_byte [7:0]
    output logic                        o_m_tvalid,
    input  wire logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0]      o_m_tdata    // codepoint [20:0], zero [23:21]
);

    // Input register: holds one accepted byte until it is decoded.
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;

    // Pending sequence state.
    logic [PART_W-1:0] r_partial;
    logic [OWED_W-1:0] r_owed;

    // Result register.
    logic              r_out_valid;
    logic [CP_W-1:0]   r_out_cp;

    logic              out_free;
    logic              dec_fire;
    logic              in_accept;
    t_dec_result       dec;

    // The result register can take a new codepoint when it is empty or is
    // being drained in this cycle.
    assign out_free   = !r_out_valid || i_m_tready;
    // The held byte is decoded once the result register has room, whether or
    // not it completes a codepoint.
    assign dec_fire   = r_in_valid && out_free;
    assign o_s_tready = !r_in_valid || dec_fire;
    assign in_accept  = i_s_tvalid && o_s_tready;

    assign dec = f_decode(r_owed, r_partial, r_in_byte);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (dec_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte <= i_s_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial <= '0;
            r_owed    <= '0;
        end else if (dec_fire) begin
            r_partial <= dec.next_partial;
            r_owed    <= dec.next_owed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (dec_fire && dec.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (dec_fire && dec.emit) begin
            r_out_cp <= dec.cp;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_TDATA_W-CP_W){1'b0}}, r_out_cp};

endmodule

`default_nettype wire

/* rtl/utf8_dec_checker.sv */
// Port-level checker for the UTF-8 decoder and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module utf8_dec_checker
    import utf8_dec_pkg::*;
(
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   i_s_tvalid,
    input wire logic                   o_s_tready,
    input wire logic [BYTE_W-1:0]      i_s_tdata,
    input wire logic                   o_m_tvalid,
    input wire logic                   i_m_tready,
    input wire logic [OUT_TDATA_W-1:0] o_m_tdata
);

    logic s_seen;
    assign s_seen = i_s_tvalid && o_s_tready && (i_s_tdata != '0);

    // A stalled result keeps its codepoint.
    `ASSERT_RST(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
    // Zero codepoints are never delivered.
    `ASSERT_RST(a_out_nonzero, i_clk, i_rst_n, o_m_tvalid |-> o_m_tdata[CP_W-1:0] != '0)
    // The pad bits above the codepoint stay zero.
    `ASSERT_RST(a_out_pad, i_clk, i_rst_n, o_m_tvalid |-> o_m_tdata[OUT_TDATA_W-1:CP_W] == '0)
    // Reset empties the result register, and it is also empty when a reset cycle is
    // followed by a cycle that accepts no non-zero byte, in the cycle after that one.
    `ASSERT_CLK(a_rst_empty, i_clk, !i_rst_n |=> !o_m_tvalid)
    `ASSERT_CLK(a_no_early_out, i_clk, !i_rst_n ##1 !s_seen |=> !o_m_tvalid)

endmodule

bind utf8_to_codepoint_decoder_top utf8_dec_checker u_utf8_dec_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

`default_nettype wire
